// ===== design/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

  // Default depth of the ring store
  localparam int DQ_CAPACITY = 16;

  // Operation codes
  localparam logic [1:0] FN_PUSH_LEFT  = 2'd0;
  localparam logic [1:0] FN_PUSH_RIGHT = 2'd1;
  localparam logic [1:0] FN_POP_LEFT   = 2'd2;
  localparam logic [1:0] FN_POP_RIGHT  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } dq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;
    logic               is_empty;
    logic               is_full;
    logic [4:0]         fill_count;
  } dq_out_t;

endpackage

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  dq_in_t  (func, value)
// out_      output     out_valid/out_stall  dq_out_t (status, peeks, flags, count)
//
// A push, a refused operation or a pop of the last element goes straight to the result
// register; any other pop first waits in S_READ, since the new end element comes back
// from the registered read port of the ring memory.
// One transaction is in flight at a time; the result register frees the input side
// as soon as the pending result is taken.
// rst_n (synchronous) clears the head pointer, count and control; no clearing pass.
// in_stall is high while a pop waits on its read or while a result waits on out_stall.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY = DQ_CAPACITY
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dq_in_t  in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output dq_out_t      out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] SUM_CAP  = SUM_W'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  // Control and peek registers
  logic             state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             pend_left_r, pend_left_nxt;
  logic [31:0]      left_r, left_nxt;
  logic [31:0]      right_r, right_nxt;

  // Ring memory
  logic [31:0]      ring_mem [CAPACITY];
  logic [31:0]      rd_data_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  logic             out_blocked, accept, complete;
  logic             is_full_now, is_empty_now;
  logic [IDX_W-1:0] head_inc, head_dec, tail_pos, last_m1_pos;
  logic [SUM_W-1:0] tail_sum, last_m1_sum;

  assign out_blocked = out_valid_r && out_stall;
  assign in_stall    = (state_r != S_IDLE) || out_blocked;
  assign accept      = in_valid && !in_stall;
  assign complete    = (state_r == S_READ) && !out_blocked;

  assign is_full_now  = (occ_r == CNT_FULL);
  assign is_empty_now = (occ_r == '0);

  // Ring index arithmetic, wrapped by one compare
  assign head_inc    = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
  assign head_dec    = (head_r == '0) ? IDX_LAST : head_r - 1'b1;
  assign tail_sum    = SUM_W'(head_r) + SUM_W'(occ_r);
  assign tail_pos    = (tail_sum >= SUM_CAP) ? IDX_W'(tail_sum - SUM_CAP) : IDX_W'(tail_sum);
  assign last_m1_sum = SUM_W'(head_r) + SUM_W'(occ_r) - SUM_W'(2);
  assign last_m1_pos = (last_m1_sum >= SUM_CAP) ? IDX_W'(last_m1_sum - SUM_CAP)
                                                : IDX_W'(last_m1_sum);

  // Operation decode and state update
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    status_nxt    = status_r;
    pend_left_nxt = pend_left_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    wr_addr       = head_dec;
    rd_addr       = head_inc;
    out_valid_nxt = out_valid_r && out_stall;

    if (accept) begin
      unique case (in_data.func)
        FN_PUSH_LEFT, FN_PUSH_RIGHT: begin
          if (is_full_now) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_OK;
            mem_we     = 1'b1;
            occ_nxt    = occ_r + 1'b1;
            if (in_data.func == FN_PUSH_LEFT) begin
              wr_addr  = head_dec;
              head_nxt = head_dec;
              left_nxt = in_data.value;
              if (is_empty_now) right_nxt = in_data.value;
            end else begin
              wr_addr   = tail_pos;
              right_nxt = in_data.value;
              if (is_empty_now) left_nxt = in_data.value;
            end
          end
          out_valid_nxt = 1'b1;
        end
        FN_POP_LEFT, FN_POP_RIGHT: begin
          if (is_empty_now) begin
            status_nxt    = ST_EMPTY;
            out_valid_nxt = 1'b1;
          end else begin
            status_nxt    = ST_OK;
            occ_nxt       = occ_r - 1'b1;
            pend_left_nxt = (in_data.func == FN_POP_LEFT);
            if (in_data.func == FN_POP_LEFT) begin
              head_nxt = head_inc;
              rd_addr  = head_inc;
            end else begin
              rd_addr  = last_m1_pos;
            end
            if (occ_r == CNT_W'(1)) begin
              // last element leaves: nothing to fetch
              out_valid_nxt = 1'b1;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_READ;
            end
          end
        end
        default: begin
          status_nxt = status_r;
        end
      endcase
    end

    // New end element has arrived from memory
    if (complete) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      if (pend_left_r) begin
        left_nxt = rd_data_r;
        if (occ_r == CNT_W'(1)) right_nxt = rd_data_r;
      end else begin
        right_nxt = rd_data_r;
        if (occ_r == CNT_W'(1)) left_nxt = rd_data_r;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    pend_left_r <= pend_left_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[wr_addr] <= in_data.value;
    if (mem_re) rd_data_r <= ring_mem[rd_addr];
  end

  // Result
  assign out_valid               = out_valid_r;
  assign out_data.status         = status_r;
  assign out_data.left_value     = is_empty_now ? '0 : left_r;
  assign out_data.right_value    = is_empty_now ? '0 : right_r;
  assign out_data.is_empty       = is_empty_now;
  assign out_data.is_full        = is_full_now;
  assign out_data.fill_count     = 5'(occ_r);

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_FULL)
    else $error("occupancy above capacity");

  a_read_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> in_stall && !out_valid_r)
    else $error("input taken or result shown while a read is pending");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_full_now &&
    (in_data.func == FN_PUSH_LEFT || in_data.func == FN_PUSH_RIGHT)
    |=> out_valid_r && status_r == ST_OK && !is_empty_now)
    else $error("accepted push did not give an ok result next cycle");

  a_pop_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && occ_r > CNT_W'(1) &&
    (in_data.func == FN_POP_LEFT || in_data.func == FN_POP_RIGHT)
    |=> state_r == S_READ && occ_r == $past(occ_r) - 1'b1)
    else $error("pop did not start a read of the new end");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top
  import dq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic    clk;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  dq_in_t  in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  dq_out_t out_data;

  // Random gaps on the input side and stalls on the output side
  bit gaps_on = 1'b0;
  int error_count = 0;

  // Mirror of the deque contents
  logic signed [31:0] deque_words [DQ_CAPACITY];
  int                 head_pos = 0;
  int                 word_count = 0;

  // Results waiting for the block, oldest first
  dq_out_t pending_results [$];
  dq_out_t want;

  double_ended_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one operation to the mirror and return the result it produces
  function automatic dq_out_t apply_deque_op(dq_in_t item);
    dq_out_t res;
    res = '0;
    res.status = ST_OK;
    case (item.func)
      FN_PUSH_LEFT, FN_PUSH_RIGHT: begin
        if (word_count >= DQ_CAPACITY) begin
          res.status = ST_FULL;
        end else if (item.func == FN_PUSH_LEFT) begin
          head_pos = (head_pos + DQ_CAPACITY - 1) % DQ_CAPACITY;
          deque_words[head_pos] = item.value;
          word_count++;
        end else begin
          deque_words[(head_pos + word_count) % DQ_CAPACITY] = item.value;
          word_count++;
        end
      end
      default: begin
        if (word_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // pop left moves the head, pop right only shrinks the count
          if (item.func == FN_POP_LEFT) head_pos = (head_pos + 1) % DQ_CAPACITY;
          word_count--;
        end
      end
    endcase
    if (word_count != 0) begin
      res.left_value  = deque_words[head_pos];
      res.right_value = deque_words[(head_pos + word_count - 1) % DQ_CAPACITY];
    end
    res.is_empty   = (word_count == 0);
    res.is_full    = (word_count >= DQ_CAPACITY);
    res.fill_count = 5'(word_count);
    return res;
  endfunction

  // Drive one transaction, hold it until accepted, then record its result
  task automatic send_op(input logic [1:0] fn, input logic signed [31:0] val);
    dq_in_t item;
    item.func  = fn;
    item.value = val;
    while (gaps_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_deque_op(item));
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 35);
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      error_count++;
      $display("%0t ns: %s expected %0h got %0h", $time, name, want_v, got_v);
    end
  endtask

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: result with none expected, got %0h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("left_value", want.left_value, out_data.left_value);
        check_field("right_value", want.right_value, out_data.right_value);
        check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
        check_field("is_full", 32'(want.is_full), 32'(out_data.is_full));
        check_field("fill_count", 32'(want.fill_count), 32'(out_data.fill_count));
      end
    end
  end

  // Empty pops, extreme words, last element leaving from either end
  task automatic test_directed_ends();
    send_op(FN_POP_LEFT, $urandom);
    send_op(FN_POP_RIGHT, $urandom);
    send_op(FN_PUSH_LEFT, 32'sh8000_0000);
    send_op(FN_POP_RIGHT, $urandom);
    send_op(FN_PUSH_RIGHT, 32'sh7fff_ffff);
    send_op(FN_POP_LEFT, $urandom);
    send_op(FN_PUSH_RIGHT, -32'sd1);
    send_op(FN_PUSH_LEFT, 32'sd0);
    send_op(FN_PUSH_LEFT, 32'sh5555_5555);
    send_op(FN_PUSH_RIGHT, 32'shaaaa_aaaa);
    send_op(FN_POP_LEFT, $urandom);
    send_op(FN_POP_RIGHT, $urandom);
    send_op(FN_POP_RIGHT, $urandom);
    send_op(FN_POP_LEFT, $urandom);
    send_op(FN_POP_RIGHT, $urandom);
  endtask

  // Fill to capacity, push into a full deque, then drain past empty
  task automatic test_fill_and_drain();
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < DQ_CAPACITY; i++)
        send_op($urandom_range(1) ? FN_PUSH_LEFT : FN_PUSH_RIGHT, $urandom);
      send_op(FN_PUSH_LEFT, $urandom);
      send_op(FN_PUSH_RIGHT, $urandom);
      for (int i = 0; i < DQ_CAPACITY; i++)
        send_op((i % 2 == pass) ? FN_POP_LEFT : FN_POP_RIGHT, $urandom);
      send_op(FN_POP_LEFT, $urandom);
    end
  endtask

  // Bursts biased toward pushes, pops or neither, so the count sweeps 0..full
  task automatic test_random_mix(input int n_items);
    int                 burst_left;
    int                 push_pct;
    logic [1:0]         fn;
    logic signed [31:0] val;
    burst_left = 0;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      // first stretch runs back to back with no gaps or stalls
      gaps_on = (i >= 300);
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 4);
        case ($urandom_range(2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      burst_left--;
      if ($urandom_range(99) < push_pct)
        fn = $urandom_range(1) ? FN_PUSH_LEFT : FN_PUSH_RIGHT;
      else
        fn = $urandom_range(1) ? FN_POP_LEFT : FN_POP_RIGHT;
      case ($urandom_range(9))
        0: val = 32'sh8000_0000;
        1: val = 32'sh7fff_ffff;
        2: val = $urandom_range(1) ? 32'sd0 : -32'sd1;
        default: val = $urandom;
      endcase
      send_op(fn, val);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    gaps_on = 1'b1;
    test_directed_ends();
    test_fill_and_drain();
    test_random_mix(1600);
    in_valid <= 1'b0;

    // let the last results drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("double_ended_queue: match");
    else
      $display("double_ended_queue: mismatch");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("double_ended_queue: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/dq_pkg.sv
design/double_ended_queue.sv
sim/tb_top.sv
